FILE: rtl/assert_macros.svh
// Assertion macros for the scheduler RTL.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check an implication in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// No dependencies.
`default_nettype none
package mlfq_pkg;
  localparam int MAX_LEVELS = 8;
  localparam int MAX_PROCS  = 16;

  localparam logic       CMD_ADMIT    = 1'b0;
  localparam logic       CMD_RUN      = 1'b1;
  localparam logic [1:0] OUT_YIELD    = 2'd0;
  localparam logic [1:0] OUT_FULL     = 2'd1;

  localparam logic [2:0] KIND_RUN     = 3'd0;
  localparam logic [2:0] KIND_EXIT    = 3'd1;
  localparam logic [2:0] KIND_BOOST   = 3'd2;
  localparam logic [2:0] KIND_IDLE    = 3'd3;
  localparam logic [2:0] KIND_ADMIT   = 3'd4;
  localparam logic [2:0] KIND_REJECT  = 3'd5;

  localparam logic       REG_NUM_LEVELS   = 1'b0;
  localparam logic       REG_BOOST_PERIOD = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [4:0] admit_pid;
    logic [1:0] slice_outcome;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] pid;
    logic [3:0] level;
    logic       full_quantum;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_EMIT,
    ST_BREAD,
    ST_BMOVE,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/mlfq_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_ram and assert_macros.svh.
//
// An admit goes from idle straight to the output state. A run reads the head
// pid, emits its result, then moves each boosted process with a read state and
// a move state, one process at a time, set by the single read port of the queue
// memory (read, then write back). The pid queues of all levels share one memory
// with one region per level; heads, tails and counts sit in flip-flops. A
// finished result waits in the output register while nothing else is accepted.
`default_nettype none
`include "assert_macros.svh"
module mlfq_scheduler #(
  parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS,
  parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mlfq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mlfq_pkg::out_item_t      out_data
);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int DEPTH = MAX_LEVELS * MAX_PROCS;
  localparam int AW = $clog2(DEPTH);

  logic [3:0]  num_levels_r;
  logic [15:0] boost_period_r;
  logic [15:0] tick_r, tick_nxt;
  logic [PW-1:0] head_r [MAX_LEVELS];
  logic [PW-1:0] tail_r [MAX_LEVELS];
  logic [CW-1:0] cnt_r  [MAX_LEVELS];

  mlfq_pkg::state_t state_r, state_nxt;
  mlfq_pkg::in_item_t item_r;
  mlfq_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r;
  logic [LW-1:0] lv_r, lv_nxt;      // level being popped
  logic boost_r, boost_nxt;         // boost follows the current result

  // Effective level count and top level
  logic [4:0] nl;
  logic [LW-1:0] top;
  always_comb begin
    if (num_levels_r == 4'd0) begin
      nl = 5'd1;
    end else if ({1'b0, num_levels_r} > 5'(MAX_LEVELS)) begin
      nl = 5'(MAX_LEVELS);
    end else begin
      nl = {1'b0, num_levels_r};
    end
    top = LW'(nl - 5'd1);
  end

  // Total waiting and highest non-empty level at or below the top
  logic [CW+3:0] total;
  logic          found;
  logic [LW-1:0] hi_lv;
  logic [LW-1:0] b_lv;
  always_comb begin
    total = '0;
    found = 1'b0;
    hi_lv = '0;
    b_lv = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      total = total + (CW+4)'(cnt_r[i]);
      if (LW'(i) <= top && cnt_r[i] != '0) begin
        found = 1'b1;
        hi_lv = LW'(i);
      end
      if (LW'(i) < top && cnt_r[i] != '0) begin
        b_lv = LW'(i);
      end
    end
  end

  // Memory
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [4:0] wdata, rdata;
  mlfq_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] addr_of(logic [LW-1:0] l, logic [PW-1:0] s);
    logic [31:0] a;
    a = 32'(l) * 32'(MAX_PROCS) + 32'(s);
    return AW'(a);
  endfunction

  logic accept_in, out_done;
  assign accept_in = in_valid && !in_stall;
  assign out_done  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mlfq_pkg::ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Queue operations decided this cycle
  logic push_en, pop_en;
  logic [LW-1:0] push_lv, pop_lv;
  logic [4:0] push_pid;
  logic emit;
  logic [1:0] oc;
  logic [LW-1:0] dst;
  logic [31:0] pid_lim;
  logic bfound_after;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlfq_pkg::ST_IDLE:  if (accept_in) begin
        state_nxt = (in_data.cmd == mlfq_pkg::CMD_ADMIT) ? mlfq_pkg::ST_OUT
                  : (found ? mlfq_pkg::ST_POP : mlfq_pkg::ST_OUT);
      end
      mlfq_pkg::ST_POP:   state_nxt = mlfq_pkg::ST_EMIT;
      mlfq_pkg::ST_EMIT:  state_nxt = (boost_nxt && bfound_after) ? mlfq_pkg::ST_BREAD
                                                                  : mlfq_pkg::ST_OUT;
      mlfq_pkg::ST_BREAD: if (out_done) begin
        state_nxt = mlfq_pkg::ST_BMOVE;
      end
      mlfq_pkg::ST_BMOVE: state_nxt = bfound_after ? mlfq_pkg::ST_BREAD : mlfq_pkg::ST_OUT;
      mlfq_pkg::ST_OUT:   if (out_done) begin
        state_nxt = mlfq_pkg::ST_IDLE;
      end
      default:            state_nxt = mlfq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of each state
  always_comb begin
    push_en = 1'b0; pop_en = 1'b0;
    push_lv = top; pop_lv = lv_r; push_pid = rdata;
    emit = 1'b0; out_nxt = out_r;
    lv_nxt = lv_r; boost_nxt = boost_r; tick_nxt = tick_r;
    raddr = addr_of(lv_r, head_r[lv_r]);
    oc = item_r.slice_outcome;
    dst = (lv_r == '0) ? '0 : lv_r - LW'(1);
    pid_lim = 32'(MAX_PROCS);
    case (state_r)
      mlfq_pkg::ST_IDLE: begin
        lv_nxt = hi_lv;
        boost_nxt = 1'b0;
        raddr = addr_of(hi_lv, head_r[hi_lv]);
        if (accept_in && in_data.cmd == mlfq_pkg::CMD_ADMIT) begin
          if (in_data.admit_pid == 5'd0 || 32'(in_data.admit_pid) > pid_lim
              || total >= (CW+4)'(MAX_PROCS)) begin
            out_nxt = '{mlfq_pkg::KIND_REJECT, in_data.admit_pid, 4'd0, 1'b0, 1'b1};
          end else begin
            push_en = 1'b1; push_pid = in_data.admit_pid;
            out_nxt = '{mlfq_pkg::KIND_ADMIT, in_data.admit_pid, nl[3:0], 1'b0, 1'b1};
          end
        end else if (accept_in && !found) begin
          out_nxt = '{mlfq_pkg::KIND_IDLE, 5'd0, 4'd0, 1'b0, 1'b1};
        end
      end
      mlfq_pkg::ST_POP: begin
        // Memory read is in flight; wait for the registered read data
      end
      mlfq_pkg::ST_EMIT: begin
        pop_en = 1'b1;
        tick_nxt = tick_r + 16'd1;
        boost_nxt = (tick_nxt >= boost_period_r);
        if (boost_nxt) begin
          tick_nxt = '0;
        end
        if (oc == mlfq_pkg::OUT_YIELD) begin
          push_en = 1'b1; push_lv = lv_r;
          out_nxt = '{mlfq_pkg::KIND_RUN, rdata, 4'(lv_r) + 4'd1, 1'b0, 1'b0};
        end else if (oc == mlfq_pkg::OUT_FULL) begin
          push_en = 1'b1; push_lv = dst;
          out_nxt = '{mlfq_pkg::KIND_RUN, rdata, 4'(dst) + 4'd1, 1'b1, 1'b0};
        end else begin
          out_nxt = '{mlfq_pkg::KIND_EXIT, rdata, 4'd0, 1'b0, 1'b0};
        end
        emit = 1'b1;
      end
      mlfq_pkg::ST_BREAD: begin
        lv_nxt = b_lv;
        raddr = addr_of(b_lv, head_r[b_lv]);
      end
      mlfq_pkg::ST_BMOVE: begin
        pop_en = 1'b1; push_en = 1'b1;
        out_nxt = '{mlfq_pkg::KIND_BOOST, rdata, nl[3:0], 1'b0, 1'b0};
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    we = push_en;
    waddr = addr_of(push_lv, tail_r[push_lv]);
    wdata = push_pid;
  end

  // Look for a process left below the top after this cycle's pop and push
  logic [CW-1:0] cnt_after;
  always_comb begin
    bfound_after = 1'b0;
    cnt_after = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      cnt_after = cnt_r[i] + CW'(push_en && LW'(i) == push_lv)
                           - CW'(pop_en && LW'(i) == pop_lv);
      if (LW'(i) < top && cnt_after != '0) begin
        bfound_after = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tick_r <= '0;
      boost_r <= 1'b0;
      num_levels_r <= 4'd3;
      boost_period_r <= 16'd100;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      tick_r <= tick_nxt;
      boost_r <= boost_nxt;
      if (cfg_we && cfg_index == mlfq_pkg::REG_NUM_LEVELS) begin
        num_levels_r <= cfg_wdata[3:0];
      end
      if (cfg_we && cfg_index == mlfq_pkg::REG_BOOST_PERIOD) begin
        boost_period_r <= cfg_wdata;
      end
      // Output register: load on each result, drop when taken
      if (emit || (state_r == mlfq_pkg::ST_IDLE && accept_in &&
          (in_data.cmd == mlfq_pkg::CMD_ADMIT || !found))) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Pointer and count updates
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (pop_en && LW'(i) == pop_lv) begin
          head_r[i] <= (head_r[i] == PW'(MAX_PROCS - 1)) ? '0 : head_r[i] + PW'(1);
        end
        if (push_en && LW'(i) == push_lv) begin
          tail_r[i] <= (tail_r[i] == PW'(MAX_PROCS - 1)) ? '0 : tail_r[i] + PW'(1);
        end
        cnt_r[i] <= cnt_r[i] + CW'(push_en && LW'(i) == push_lv)
                             - CW'(pop_en && LW'(i) == pop_lv);
      end
    end
  end

  // Payload registers; an emitted item is last when nothing follows it
  always_ff @(posedge clk) begin
    lv_r <= lv_nxt;
    if (accept_in) begin
      item_r <= in_data;
    end
    if (emit) begin
      out_r <= '{out_nxt.kind, out_nxt.pid, out_nxt.level, out_nxt.full_quantum,
                 (state_r == mlfq_pkg::ST_EMIT) ? !(boost_nxt && bfound_after)
                                                : !bfound_after};
    end else begin
      out_r <= out_nxt;
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != mlfq_pkg::ST_IDLE, in_stall)
  `ASSERT_IMPL(a_total_bound, clk, rst_n, 1'b1, total <= (CW+4)'(MAX_PROCS))
  `ASSERT_NEXT(a_emit_valid, clk, rst_n, emit, out_valid)
endmodule
`default_nettype wire

FILE: rtl/mlfq_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: test/mlfq_scheduler_test.sv
// Self-checking test of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg and mlfq_scheduler; predicts every result item in-line.
`default_nettype none
module mlfq_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 352;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = mlfq_pkg::REG_NUM_LEVELS;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  mlfq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mlfq_pkg::out_item_t out_data;

  mlfq_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scheduler shadow: one pid queue per level plus tick count
  logic [4:0] level_queues [mlfq_pkg::MAX_LEVELS][$];
  logic [3:0] sched_levels;
  logic [15:0] sched_boost_period;
  logic [15:0] sched_ticks;
  mlfq_pkg::out_item_t pending_results [$];
  int fail_count = 0;
  bit quiet_tail = 1'b0;

  function automatic int used_levels();
    if (sched_levels < 1) return 1;
    if (sched_levels > mlfq_pkg::MAX_LEVELS) return mlfq_pkg::MAX_LEVELS;
    return int'(sched_levels);
  endfunction

  function automatic int waiting_total();
    int sum;
    sum = 0;
    for (int i = 0; i < mlfq_pkg::MAX_LEVELS; i++) sum += level_queues[i].size();
    return sum;
  endfunction

  function automatic mlfq_pkg::out_item_t mk(logic [2:0] kind, logic [4:0] pid,
                                             logic [3:0] lvl, logic fq);
    mlfq_pkg::out_item_t r;
    r.kind = kind; r.pid = pid; r.level = lvl; r.full_quantum = fq; r.last = 1'b0;
    return r;
  endfunction

  // Compute the result items of one accepted item and queue them
  function automatic void schedule_item(mlfq_pkg::in_item_t it);
    int nl, top, lv;
    mlfq_pkg::out_item_t res [$];
    mlfq_pkg::out_item_t r;
    logic [4:0] pid;
    nl = used_levels();
    top = nl - 1;
    if (it.cmd == mlfq_pkg::CMD_ADMIT) begin
      if (it.admit_pid < 1 || it.admit_pid > mlfq_pkg::MAX_PROCS
          || waiting_total() >= mlfq_pkg::MAX_PROCS) begin
        res = {res, mk(mlfq_pkg::KIND_REJECT, it.admit_pid, 4'd0, 1'b0)};
      end else begin
        level_queues[top] = {level_queues[top], it.admit_pid};
        res = {res, mk(mlfq_pkg::KIND_ADMIT, it.admit_pid, 4'(nl), 1'b0)};
      end
    end else begin
      lv = top;
      while (lv >= 0 && level_queues[lv].size() == 0) lv--;
      if (lv < 0) begin
        res = {res, mk(mlfq_pkg::KIND_IDLE, 5'd0, 4'd0, 1'b0)};
      end else begin
        pid = level_queues[lv].pop_front();
        if (it.slice_outcome >= 2) begin
          res = {res, mk(mlfq_pkg::KIND_EXIT, pid, 4'd0, 1'b0)};
        end else if (it.slice_outcome == mlfq_pkg::OUT_YIELD) begin
          level_queues[lv] = {level_queues[lv], pid};
          res = {res, mk(mlfq_pkg::KIND_RUN, pid, 4'(lv + 1), 1'b0)};
        end else begin
          if (lv > 0) lv--;
          level_queues[lv] = {level_queues[lv], pid};
          res = {res, mk(mlfq_pkg::KIND_RUN, pid, 4'(lv + 1), 1'b1)};
        end
        sched_ticks = sched_ticks + 16'd1;
        if (sched_ticks >= sched_boost_period) begin
          for (int j = top - 1; j >= 0; j--) begin
            while (level_queues[j].size() != 0 && res.size() < 1 + mlfq_pkg::MAX_PROCS) begin
              pid = level_queues[j].pop_front();
              level_queues[top] = {level_queues[top], pid};
              res = {res, mk(mlfq_pkg::KIND_BOOST, pid, 4'(nl), 1'b0)};
            end
          end
          sched_ticks = '0;
        end
      end
    end
    r = res[$];
    r.last = 1'b1;
    res[$] = r;
    foreach (res[k]) pending_results = {pending_results, res[k]};
  endfunction

  // Check each accepted result item against the oldest expectation
  always @(posedge clk) begin
    mlfq_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item kind=%0d pid=%0d", out_data.kind, out_data.pid);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind expected %0d actual %0d", exp_r.kind, out_data.kind); fail_count++;
        end
        if (out_data.pid !== exp_r.pid) begin
          $error("pid expected %0d actual %0d", exp_r.pid, out_data.pid); fail_count++;
        end
        if (out_data.level !== exp_r.level) begin
          $error("level expected %0d actual %0d", exp_r.level, out_data.level); fail_count++;
        end
        if (out_data.full_quantum !== exp_r.full_quantum) begin
          $error("full_quantum expected %0d actual %0d", exp_r.full_quantum,
                 out_data.full_quantum);
          fail_count++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_data.last); fail_count++;
        end
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Write one register, then leave the port idle before returning
  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mlfq_pkg::REG_NUM_LEVELS) sched_levels = value[3:0];
    else sched_boost_period = value;
    @(posedge clk);
  endtask

  // Wait for every expected item plus a margin before touching registers
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Present one item and hold it until accepted
  task automatic send_item(mlfq_pkg::in_item_t it, bit allow_gap);
    if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_item(it);
  endtask

  function automatic mlfq_pkg::in_item_t make_item(logic cmd, logic [4:0] pid,
                                                   logic [1:0] oc);
    mlfq_pkg::in_item_t it;
    it.cmd = cmd; it.admit_pid = pid; it.slice_outcome = oc;
    return it;
  endfunction

  // Directed table: cmd, pid, outcome, expected kind (KIND_RUN means predictor only)
  typedef struct {
    logic cmd;
    logic [4:0] pid;
    logic [1:0] oc;
    logic [2:0] kind_hint;
  } row_t;

  row_t directed [] = '{
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_YIELD, mlfq_pkg::KIND_IDLE},
    '{mlfq_pkg::CMD_ADMIT, 5'd0, 2'd0, mlfq_pkg::KIND_REJECT},
    '{mlfq_pkg::CMD_ADMIT, 5'd17, 2'd0, mlfq_pkg::KIND_REJECT},
    '{mlfq_pkg::CMD_ADMIT, 5'd31, 2'd3, mlfq_pkg::KIND_REJECT},
    '{mlfq_pkg::CMD_ADMIT, 5'd1, 2'd0, mlfq_pkg::KIND_ADMIT},
    '{mlfq_pkg::CMD_ADMIT, 5'd16, 2'd0, mlfq_pkg::KIND_ADMIT},
    '{mlfq_pkg::CMD_ADMIT, 5'd1, 2'd0, mlfq_pkg::KIND_ADMIT},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_YIELD, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, 2'd3, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, 2'd2, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd0, 2'd2, mlfq_pkg::KIND_RUN},
    '{mlfq_pkg::CMD_RUN, 5'd31, 2'd2, mlfq_pkg::KIND_IDLE}
  };

  initial begin
    mlfq_pkg::in_item_t it;
    int r;
    mlfq_pkg::out_item_t hint;
    foreach (level_queues[i]) level_queues[i] = {};
    sched_levels = 4'd3;
    sched_boost_period = 16'd100;
    sched_ticks = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings
    foreach (directed[i]) begin
      it = make_item(directed[i].cmd, directed[i].pid, directed[i].oc);
      send_item(it, 1'b0);
      hint = pending_results[$];
      if (directed[i].kind_hint != mlfq_pkg::KIND_RUN && hint.kind != directed[i].kind_hint)
      begin
        $error("kind expected %0d actual %0d (row %0d)", directed[i].kind_hint, hint.kind, i);
        fail_count++;
      end
    end
    in_valid <= 1'b0;
    wait_idle();

    // Extremes: max levels with boost every slice, fill to capacity
    write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd15);
    write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd0);
    for (int p = 1; p <= mlfq_pkg::MAX_PROCS + 1; p++) begin
      send_item(make_item(mlfq_pkg::CMD_ADMIT, 5'(p), 2'd0), 1'b1);
    end
    for (int k = 0; k < 8; k++) begin
      send_item(make_item(mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL), 1'b1);
    end
    in_valid <= 1'b0;
    wait_idle();
    write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd65535);
    for (int k = 0; k < 20; k++) begin
      send_item(make_item(mlfq_pkg::CMD_RUN, 5'd0, mlfq_pkg::OUT_FULL), 1'b1);
    end
    in_valid <= 1'b0;
    wait_idle();
    // Strand processes in upper levels, then a single level
    write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd0);
    write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd1);
    for (int k = 0; k < 6; k++) begin
      send_item(make_item(mlfq_pkg::CMD_RUN, 5'd0, 2'($urandom_range(0, 1))), 1'b1);
    end
    in_valid <= 1'b0;
    wait_idle();

    // Random phases, each with its own settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd8);
          write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd5);
        end
        1: begin
          write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd1);
          write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd3);
        end
        2: begin
          write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd4);
          write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd65535);
        end
        3: begin
          write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'd2);
          write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'd0);
        end
        default: begin
          write_reg(mlfq_pkg::REG_NUM_LEVELS, 16'($urandom_range(0, 15)));
          write_reg(mlfq_pkg::REG_BOOST_PERIOD, 16'($urandom_range(1, 12)));
        end
      endcase
      if (ph == 6) quiet_tail = 1'b1;
      for (int k = 0; k < NUM_RANDOM / 8; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          it = make_item(mlfq_pkg::CMD_ADMIT, 5'($urandom_range(1, mlfq_pkg::MAX_PROCS)),
                         2'($urandom));
        end else if (r < 45) begin
          it = make_item(mlfq_pkg::CMD_ADMIT, 5'($urandom), 2'($urandom));
        end else if (r < 90) begin
          it = make_item(mlfq_pkg::CMD_RUN, 5'($urandom), 2'($urandom_range(0, 2)));
        end else begin
          it = make_item(mlfq_pkg::CMD_RUN, 5'($urandom), 2'($urandom));
        end
        send_item(it, 1'b1);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) $display("mlfq_scheduler_test passed");
    else $display("mlfq_scheduler_test failed");
    $finish;
  end

  // Run limit
  initial begin
    #4ms;
    $display("mlfq_scheduler_test failed");
    $finish;
  end
endmodule
`default_nettype wire
